### rtl/matrix3x3_inverse_assert.svh
// Assertion macros for the 3x3 matrix inverse block.
// Included by the top level; relies on i_clk and i_rst_n in scope.
`ifndef MATRIX3X3_INVERSE_ASSERT_SVH
`define MATRIX3X3_INVERSE_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define MI3_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define MI3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mi3_pkg.sv
// Shared types and widths for the 3x3 matrix inverse block.
// No dependencies.
package mi3_pkg;

    localparam int ELEM_W = 32;
    localparam int PROD_W = 64;
    localparam int ADJ_W  = 65;
    localparam int DET_W  = 97;
    localparam int QUO_W  = 32;
    localparam int N_ELEM = 9;

    localparam int unsigned COF_IDX [N_ELEM][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };
    localparam int unsigned COL0_IDX [3] = '{0, 3, 6};

    typedef logic [N_ELEM-1:0][ELEM_W-1:0] t_elem_vec;
    typedef logic [N_ELEM-1:0][ADJ_W-1:0]  t_adj_vec;
    typedef logic [2:0][ELEM_W-1:0]        t_col_vec;

    typedef struct packed {
        logic signed [ELEM_W-1:0] in_r0c0;
        logic signed [ELEM_W-1:0] in_r0c1;
        logic signed [ELEM_W-1:0] in_r0c2;
        logic signed [ELEM_W-1:0] in_r1c0;
        logic signed [ELEM_W-1:0] in_r1c1;
        logic signed [ELEM_W-1:0] in_r1c2;
        logic signed [ELEM_W-1:0] in_r2c0;
        logic signed [ELEM_W-1:0] in_r2c1;
        logic signed [ELEM_W-1:0] in_r2c2;
    } t_mat_in;

    typedef struct packed {
        logic signed [ELEM_W-1:0] out_r0c0;
        logic signed [ELEM_W-1:0] out_r0c1;
        logic signed [ELEM_W-1:0] out_r0c2;
        logic signed [ELEM_W-1:0] out_r1c0;
        logic signed [ELEM_W-1:0] out_r1c1;
        logic signed [ELEM_W-1:0] out_r1c2;
        logic signed [ELEM_W-1:0] out_r2c0;
        logic signed [ELEM_W-1:0] out_r2c1;
        logic signed [ELEM_W-1:0] out_r2c2;
        logic                     singular;
    } t_mat_out;

endpackage

### rtl/mi3_adj.sv
// Adjugate stages: pairwise element products, then cofactor differences.
// Depends on mi3_pkg.
module mi3_adj (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  mi3_pkg::t_elem_vec i_elem,
    output logic               o_vld,
    output mi3_pkg::t_adj_vec  o_adj,
    output mi3_pkg::t_col_vec  o_col
);
    import mi3_pkg::*;

    logic signed [PROD_W-1:0] r_pa [N_ELEM];
    logic signed [PROD_W-1:0] r_pb [N_ELEM];
    t_col_vec                 r_col1;
    t_col_vec                 r_col2;
    t_adj_vec                 r_adj;
    logic                     r_vld1;
    logic                     r_vld2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N_ELEM; k++) begin
            r_pa[k] <= $signed(i_elem[COF_IDX[k][0]]) * $signed(i_elem[COF_IDX[k][1]]);
            r_pb[k] <= $signed(i_elem[COF_IDX[k][2]]) * $signed(i_elem[COF_IDX[k][3]]);
            r_adj[k] <= {r_pa[k][PROD_W-1], r_pa[k]} - {r_pb[k][PROD_W-1], r_pb[k]};
        end
        for (int c = 0; c < 3; c++) begin
            r_col1[c] <= i_elem[COL0_IDX[c]];
        end
        r_col2 <= r_col1;
    end

    assign o_vld = r_vld2;
    assign o_adj = r_adj;
    assign o_col = r_col2;
endmodule

### rtl/mi3_det.sv
// Determinant stages: split products of column 0 with cofactors, term
// assembly, sum, and sign/magnitude preparation for the dividers. Uses mi3_pkg.
module mi3_det #(
    parameter  int FRAC_BITS = 16,
    localparam int NUM_W     = mi3_pkg::PROD_W + 2 * FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_vld,
    input  mi3_pkg::t_adj_vec                  i_adj,
    input  mi3_pkg::t_col_vec                  i_col,
    output logic                               o_vld,
    output logic [mi3_pkg::N_ELEM-1:0][NUM_W-1:0] o_num,
    output logic [mi3_pkg::N_ELEM-1:0]         o_neg,
    output logic [mi3_pkg::DET_W-1:0]          o_den,
    output logic                               o_zero
);
    import mi3_pkg::*;

    logic signed [ADJ_W-1:0] r_plo [3];
    logic signed [ADJ_W-1:0] r_phi [3];
    logic signed [DET_W-1:0] r_term [3];
    logic signed [DET_W-1:0] r_det;
    t_adj_vec                r_adj_c;
    t_adj_vec                r_adj_d;
    t_adj_vec                r_adj_e;
    logic [N_ELEM-1:0][NUM_W-1:0] r_num;
    logic [N_ELEM-1:0]       r_neg;
    logic [DET_W-1:0]        r_den;
    logic                    r_zero;
    logic [3:0]              r_vld;
    logic [DET_W-1:0]        n_det_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    assign n_det_mag = r_det[DET_W-1] ? DET_W'(-r_det) : DET_W'(r_det);

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_plo[c] <= $signed(i_col[c]) * $signed({1'b0, i_adj[c][ELEM_W-1:0]});
            r_phi[c] <= $signed(i_col[c]) * $signed(i_adj[c][ADJ_W-1:ELEM_W]);
            r_term[c] <= (DET_W'(r_phi[c]) <<< ELEM_W) + DET_W'(r_plo[c]);
        end
        r_det   <= r_term[0] + r_term[1] + r_term[2];
        r_adj_c <= i_adj;
        r_adj_d <= r_adj_c;
        r_adj_e <= r_adj_d;
        for (int k = 0; k < N_ELEM; k++) begin
            r_neg[k] <= r_adj_e[k][ADJ_W-1] ^ r_det[DET_W-1];
            r_num[k] <= {(r_adj_e[k][ADJ_W-1] ? PROD_W'(-$signed(r_adj_e[k]))
                                              : r_adj_e[k][PROD_W-1:0]),
                         {(2 * FRAC_BITS){1'b0}}};
        end
        r_den  <= n_det_mag;
        r_zero <= (r_det == '0);
    end

    assign o_vld  = r_vld[3];
    assign o_num  = r_num;
    assign o_neg  = r_neg;
    assign o_den  = r_den;
    assign o_zero = r_zero;
endmodule

### rtl/mi3_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow
// detection, truncation toward zero and saturation. Uses mi3_pkg.
module mi3_div #(
    parameter  int FRAC_BITS = 16,
    localparam int NUM_W     = mi3_pkg::PROD_W + 2 * FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [NUM_W-1:0]            i_num,
    input  logic [mi3_pkg::DET_W-1:0]   i_den,
    input  logic                        i_neg,
    input  logic                        i_zero,
    output logic                        o_vld,
    output logic [mi3_pkg::QUO_W-1:0]   o_quo,
    output logic                        o_zero
);
    import mi3_pkg::*;

    logic             r_vld  [QUO_W+1];
    logic [DET_W-1:0] r_rem  [QUO_W+1];
    logic [QUO_W-1:0] r_lo   [QUO_W+1];
    logic [QUO_W-1:0] r_q    [QUO_W+1];
    logic [DET_W-1:0] r_den  [QUO_W+1];
    logic             r_neg  [QUO_W+1];
    logic             r_ovf  [QUO_W+1];
    logic             r_zero [QUO_W+1];
    logic             r_out_vld;
    logic [QUO_W-1:0] r_out_quo;
    logic             r_out_zero;
    logic [DET_W-1:0] n_hi;
    logic [QUO_W-1:0] n_sat;
    logic [QUO_W-1:0] n_qf;

    assign n_hi = DET_W'(i_num[NUM_W-1:QUO_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= n_hi;
        r_lo[0]   <= i_num[QUO_W-1:0];
        r_q[0]    <= '0;
        r_den[0]  <= i_den;
        r_neg[0]  <= i_neg;
        r_ovf[0]  <= (n_hi >= i_den);
        r_zero[0] <= i_zero;
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_step
        logic [DET_W:0] n_shift;
        logic           n_ge;

        assign n_shift = {r_rem[k-1], r_lo[k-1][QUO_W-1]};
        assign n_ge    = (n_shift >= {1'b0, r_den[k-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_ge ? DET_W'(n_shift - {1'b0, r_den[k-1]}) : n_shift[DET_W-1:0];
            r_lo[k]   <= r_lo[k-1] << 1;
            r_q[k]    <= {r_q[k-1][QUO_W-2:0], n_ge};
            r_den[k]  <= r_den[k-1];
            r_neg[k]  <= r_neg[k-1];
            r_ovf[k]  <= r_ovf[k-1];
            r_zero[k] <= r_zero[k-1];
        end
    end

    assign n_qf = r_q[QUO_W];

    always_comb begin
        if (!r_neg[QUO_W]) begin
            n_sat = (r_ovf[QUO_W] || n_qf[QUO_W-1]) ? {1'b0, {(QUO_W-1){1'b1}}} : n_qf;
        end else begin
            n_sat = (r_ovf[QUO_W] || n_qf > {1'b1, {(QUO_W-1){1'b0}}})
                  ? {1'b1, {(QUO_W-1){1'b0}}} : QUO_W'(-n_qf);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_quo  <= r_zero[QUO_W] ? '0 : n_sat;
        r_out_zero <= r_zero[QUO_W];
    end

    assign o_vld  = r_out_vld;
    assign o_quo  = r_out_quo;
    assign o_zero = r_out_zero;
endmodule

### rtl/matrix3x3_inverse.sv
// Top level of the 3x3 matrix inverse in signed fixed point.
// Depends on mi3_pkg, mi3_adj, mi3_det, mi3_div and the assertion header.
//
// Usage: drive a matrix on i_mat and raise start for one cycle per
// transfer. busy is always low, so a new matrix may be started in every
// cycle and one inverse per cycle is sustained.
// Each result appears on o_result for exactly one cycle with o_done high.
// A taken start passes through the two adjugate stages, four determinant
// stages and the dividers, which retire one quotient bit per stage over
// 32 stages plus an entry and a saturation stage.
// Results leave in the order of entry.
// A zero determinant gives a result with singular set and all entries 0.
// Quotients are truncated toward zero and saturated to 32 bits.
// Reset is synchronous and clears all valid bits; matrices in flight are
// dropped. The receiver cannot stall, and no back pressure exists.
module matrix3x3_inverse #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  mi3_pkg::t_mat_in  i_mat,
    output logic              o_done,
    output mi3_pkg::t_mat_out o_result
);
    import mi3_pkg::*;

    localparam int NUM_W   = PROD_W + 2 * FRAC_BITS;
    localparam int LATENCY = 2 + 4 + QUO_W + 2;

    t_elem_vec                    w_elem;
    logic                         w_adj_vld;
    t_adj_vec                     w_adj;
    t_col_vec                     w_col;
    logic                         w_det_vld;
    logic [N_ELEM-1:0][NUM_W-1:0] w_num;
    logic [N_ELEM-1:0]            w_neg;
    logic [DET_W-1:0]             w_den;
    logic                         w_zero;
    logic [N_ELEM-1:0]            w_q_vld;
    logic [N_ELEM-1:0][QUO_W-1:0] w_quo;
    logic [N_ELEM-1:0]            w_q_zero;

    assign busy = 1'b0;

    assign w_elem = {i_mat.in_r2c2, i_mat.in_r2c1, i_mat.in_r2c0,
                     i_mat.in_r1c2, i_mat.in_r1c1, i_mat.in_r1c0,
                     i_mat.in_r0c2, i_mat.in_r0c1, i_mat.in_r0c0};

    mi3_adj u_adj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !busy),
        .i_elem  (w_elem),
        .o_vld   (w_adj_vld),
        .o_adj   (w_adj),
        .o_col   (w_col)
    );

    mi3_det #(.FRAC_BITS(FRAC_BITS)) u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_adj_vld),
        .i_adj   (w_adj),
        .i_col   (w_col),
        .o_vld   (w_det_vld),
        .o_num   (w_num),
        .o_neg   (w_neg),
        .o_den   (w_den),
        .o_zero  (w_zero)
    );

    for (genvar k = 0; k < N_ELEM; k++) begin : g_div
        mi3_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_det_vld),
            .i_num   (w_num[k]),
            .i_den   (w_den),
            .i_neg   (w_neg[k]),
            .i_zero  (w_zero),
            .o_vld   (w_q_vld[k]),
            .o_quo   (w_quo[k]),
            .o_zero  (w_q_zero[k])
        );
    end

    assign o_done = w_q_vld[0];
    assign o_result = {w_quo[0], w_quo[1], w_quo[2], w_quo[3], w_quo[4],
                       w_quo[5], w_quo[6], w_quo[7], w_quo[8], w_q_zero[0]};

`include "matrix3x3_inverse_assert.svh"

    `MI3_ASSERT_IMPLY(a_done_after_start, o_done, $past(start, LATENCY),
                      "Result without a start.")
    `MI3_ASSERT_IMPLY(a_lanes_aligned, o_done, &w_q_vld, "Divider lanes out of step.")
    `MI3_ASSERT_IMPLY(a_singular_zero, o_done && o_result.singular,
                      o_result[N_ELEM*ELEM_W:1] == '0, "Singular result not zero.")
    `MI3_ASSERT_NEXT(a_no_busy, 1'b1, !busy, "Block raised busy.")
endmodule
